// File: rtl/scba_pkg.sv
// Package for the size class block allocator: pool geometry, field widths,
// status and opcode codes, state type and the walker's interface structs.
// No dependencies.
`default_nettype none
package scba_pkg;

    localparam int COUNT_SMALL  = 10;
    localparam int COUNT_MEDIUM = 5;
    localparam int COUNT_LARGE  = 5;
    localparam int COUNT_HUGE   = 10;

    localparam int NUM_CLASSES  = 4;
    localparam int TOTAL_BLOCKS = COUNT_SMALL + COUNT_MEDIUM + COUNT_LARGE + COUNT_HUGE;

    localparam int SIZE_W = 16;
    localparam int ID_W   = 5;
    localparam int BASE_W = 10;
    localparam int LEN_W  = 7;
    localparam int CLS_W  = 2;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [BASE_W-1:0] t_base;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [CLS_W-1:0]  t_cls;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_len CLASS_SIZE [NUM_CLASSES] = '{7'd8, 7'd16, 7'd32, 7'd64};
    localparam t_cnt CLASS_COUNT [NUM_CLASSES] = '{
        CNT_W'(COUNT_SMALL), CNT_W'(COUNT_MEDIUM), CNT_W'(COUNT_LARGE), CNT_W'(COUNT_HUGE)
    };
    localparam t_len MAX_SIZE = CLASS_SIZE[NUM_CLASSES-1];
    localparam t_id  LAST_ID  = ID_W'(TOTAL_BLOCKS - 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOFREE    = 2'd1,
        ST_BADHANDLE = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        t_cls cls;
    } t_walk_ctl;

    typedef struct packed {
        t_id   id;
        t_base base;
        t_len  len;
        logic  last;
    } t_walk_pos;

    function automatic t_id class_first_id(input t_cls c);
        t_id id;
        id = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (k < int'(c)) begin
                id = id + ID_W'(CLASS_COUNT[k]);
            end
        end
        return id;
    endfunction

    function automatic t_base class_base(input t_cls c);
        t_base base;
        base = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (k < int'(c)) begin
                base = base + BASE_W'(int'(CLASS_SIZE[k]) * int'(CLASS_COUNT[k]));
            end
        end
        return base;
    endfunction

endpackage
`default_nettype wire

// File: rtl/scba_walker.sv
// Block walker: steps one block per cycle while stepped, keeping global
// block number, payload base, class and index within the class.
// Depends on scba_pkg.
`default_nettype none
module scba_walker
    import scba_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_walk_ctl i_ctl,
    output t_walk_pos      o_pos
);

    t_id   r_id,   n_id;
    t_base r_base, n_base;
    t_cls  r_cls,  n_cls;
    t_idx  r_idx,  n_idx;

    always_comb begin
        n_id   = r_id;
        n_base = r_base;
        n_cls  = r_cls;
        n_idx  = r_idx;
        if (i_ctl.load) begin
            n_id   = class_first_id(i_ctl.cls);
            n_base = class_base(i_ctl.cls);
            n_cls  = i_ctl.cls;
            n_idx  = '0;
        end else if (i_ctl.step) begin
            n_id   = r_id + 1'b1;
            n_base = r_base + BASE_W'(CLASS_SIZE[r_cls]);
            if (CNT_W'(r_idx) + 1'b1 == CLASS_COUNT[r_cls]) begin
                n_cls = r_cls + 1'b1;
                n_idx = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_base <= n_base;
        r_cls  <= n_cls;
        r_idx  <= n_idx;
    end

    assign o_pos.id   = r_id;
    assign o_pos.base = r_base;
    assign o_pos.len  = CLASS_SIZE[r_cls];
    assign o_pos.last = (r_id == LAST_ID);

endmodule
`default_nettype wire

// File: rtl/size_class_block_allocator.sv
// Top level of the size class block allocator: stream ports, used marks,
// scan sequencer and output register. Depends on scba_pkg and scba_walker.
//
// A request beat is taken only while the block is idle. The walker then visits one block per
// cycle while the scan is not stalled: an allocate starts at the first block of the smallest
// class that fits and runs upward until it finds a free block or reaches the last one; a free
// starts at block 0 and runs to the handle. Oversize requests and bad handles finish on the
// first scan state without stepping the walker. A result is held in the output register until
// taken; the next request may be accepted meanwhile, but its scan stalls on its final block
// until the register frees up. All blocks are free after reset.
`default_nettype none
module size_class_block_allocator
    import scba_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // op[0], req_size[16:1], handle[21:17]
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [M_DATA_W-1:0]      m_axis_tdata   // status[1:0], block_id[6:2],
                                                    // base_addr[16:7], block_len[23:17]
);

    t_state                  r_state, n_state;
    logic [TOTAL_BLOCKS-1:0] r_used, n_used;
    logic                    r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0]     r_out_data, n_out_data;
    t_op                     r_op, n_op;
    t_id                     r_handle, n_handle;
    logic                    r_early, n_early;
    t_status                 r_status, n_status;

    t_walk_ctl w_ctl;
    t_walk_pos w_pos;

    logic              w_accept;
    t_op               w_in_op;
    logic [SIZE_W-1:0] w_in_size;
    t_id               w_in_handle;
    logic              w_finish;
    logic              w_emit;
    logic              w_hit;

    scba_walker u_walker (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_pos (w_pos)
    );

    assign w_in_op     = t_op'(s_axis_tdata[0]);
    assign w_in_size   = s_axis_tdata[SIZE_W:1];
    assign w_in_handle = s_axis_tdata[SIZE_W+ID_W:SIZE_W+1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_op        = r_op;
        n_handle    = r_handle;
        n_early     = r_early;
        n_status    = r_status;
        w_ctl       = '0;
        w_hit       = 1'b0;
        w_finish    = 1'b0;
        w_emit      = 1'b0;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = w_in_op;
                    n_handle = w_in_handle;
                    n_early  = 1'b0;
                    n_status = ST_OK;
                    w_ctl.load = 1'b1;
                    if (w_in_op == OP_ALLOC) begin
                        if (w_in_size <= SIZE_W'(CLASS_SIZE[0])) begin
                            w_ctl.cls = CLS_W'(0);
                        end else if (w_in_size <= SIZE_W'(CLASS_SIZE[1])) begin
                            w_ctl.cls = CLS_W'(1);
                        end else if (w_in_size <= SIZE_W'(CLASS_SIZE[2])) begin
                            w_ctl.cls = CLS_W'(2);
                        end else begin
                            w_ctl.cls = CLS_W'(3);
                        end
                        if (w_in_size > SIZE_W'(MAX_SIZE)) begin
                            n_early  = 1'b1;
                            n_status = ST_NOFREE;
                        end
                    end else begin
                        w_ctl.cls = CLS_W'(0);
                        if (w_in_handle > LAST_ID) begin
                            n_early  = 1'b1;
                            n_status = ST_BADHANDLE;
                        end
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_op == OP_ALLOC) begin
                    w_hit = !r_used[w_pos.id];
                end else begin
                    w_hit = (w_pos.id == r_handle);
                end
                w_finish = r_early || w_hit || (r_op == OP_ALLOC && w_pos.last);
                w_emit   = w_finish && (!r_out_valid || m_axis_tready);
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    if (!r_early && w_hit) begin
                        n_used[w_pos.id] = (r_op == OP_ALLOC);
                        n_out_data = {w_pos.len, w_pos.base, w_pos.id, ST_OK};
                    end else if (r_early) begin
                        n_out_data = {{(M_DATA_W-2){1'b0}}, r_status};
                    end else begin
                        n_out_data = {{(M_DATA_W-2){1'b0}}, ST_NOFREE};
                    end
                    n_state = S_IDLE;
                end else if (!w_finish) begin
                    w_ctl.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_op       <= n_op;
        r_handle   <= n_handle;
        r_early    <= n_early;
        r_status   <= n_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// File: tb/tb_size_class_block_allocator.sv
// Testbench for size_class_block_allocator: drives allocate and free beats with random
// gaps and back-pressure, predicts each reply from its own copy of the used marks.
// Depends on scba_pkg and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_size_class_block_allocator;
    import scba_pkg::*;

    typedef struct packed {
        t_status status;
        t_id     id;
        t_base   base;
        t_len    len;
    } t_pool_reply;

    localparam int CLASS_BYTES [NUM_CLASSES] = '{8, 16, 32, 64};
    localparam int CLASS_BLOCKS [NUM_CLASSES] = '{COUNT_SMALL, COUNT_MEDIUM, COUNT_LARGE,
                                                  COUNT_HUGE};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // op[0], req_size[16:1], handle[21:17]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // status[1:0], block_id[6:2],
                                              // base_addr[16:7], block_len[23:17]

    logic [TOTAL_BLOCKS-1:0] block_in_use = '0;
    t_pool_reply             pending_replies[$];
    t_pool_reply             want;
    int                      mismatches = 0;
    int                      grants = 0;
    int                      rejects = 0;
    int                      releases = 0;
    int                      bad_handles = 0;
    bit                      tx_steady = 1'b0;
    bit                      rx_steady = 1'b0;
    int                      rx_hold = 0;

    size_class_block_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_pool_reply predict_pool_reply(input t_op op, input logic [15:0] size,
                                                       input logic [4:0] handle);
        t_pool_reply r;
        int          first;
        int          offset;
        bit          done;
        r = '{status: ST_NOFREE, id: '0, base: '0, len: '0};
        first = 0;
        offset = 0;
        done = 1'b0;
        if (op == OP_ALLOC) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (!done && int'(size) <= CLASS_BYTES[c]) begin
                    for (int i = 0; i < CLASS_BLOCKS[c]; i++) begin
                        if (!done && !block_in_use[first + i]) begin
                            block_in_use[first + i] = 1'b1;
                            r.status = ST_OK;
                            r.id = t_id'(first + i);
                            r.base = t_base'(offset + i * CLASS_BYTES[c]);
                            r.len = t_len'(CLASS_BYTES[c]);
                            done = 1'b1;
                        end
                    end
                end
                first += CLASS_BLOCKS[c];
                offset += CLASS_BLOCKS[c] * CLASS_BYTES[c];
            end
        end else if (int'(handle) >= TOTAL_BLOCKS) begin
            r.status = ST_BADHANDLE;
        end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (!done && int'(handle) < first + CLASS_BLOCKS[c]) begin
                    block_in_use[handle] = 1'b0;
                    r.status = ST_OK;
                    r.id = handle;
                    r.base = t_base'(offset + (int'(handle) - first) * CLASS_BYTES[c]);
                    r.len = t_len'(CLASS_BYTES[c]);
                    done = 1'b1;
                end
                first += CLASS_BLOCKS[c];
                offset += CLASS_BLOCKS[c] * CLASS_BYTES[c];
            end
        end
        return r;
    endfunction

    task automatic send_req(input t_op op, input logic [15:0] size, input logic [4:0] handle);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, handle, size, op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_replies.push_back(predict_pool_reply(op, size, handle));
    endtask

    task automatic drain_replies();
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // Hold back-pressure in random bursts, except during steady stretches.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_steady || $urandom_range(0, 3) != 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $error("reply beat with no request outstanding: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                case (want.status)
                    ST_OK:        if (want.len != '0) grants++;
                    ST_NOFREE:    rejects++;
                    default:      bad_handles++;
                endcase
                if (m_axis_tdata[1:0] != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[6:2] != want.id) begin
                    $error("block_id: expected %0d, got %0d", want.id, m_axis_tdata[6:2]);
                    mismatches++;
                end
                if (m_axis_tdata[16:7] != want.base) begin
                    $error("base_addr: expected %0d, got %0d", want.base, m_axis_tdata[16:7]);
                    mismatches++;
                end
                if (m_axis_tdata[23:17] != want.len) begin
                    $error("block_len: expected %0d, got %0d", want.len, m_axis_tdata[23:17]);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_class_boundaries();
        send_req(OP_ALLOC, 16'd0, 5'd0);
        send_req(OP_ALLOC, 16'd8, 5'd31);
        send_req(OP_ALLOC, 16'd9, 5'd0);
        send_req(OP_ALLOC, 16'd16, 5'd0);
        send_req(OP_ALLOC, 16'd17, 5'd0);
        send_req(OP_ALLOC, 16'd32, 5'd0);
        send_req(OP_ALLOC, 16'd33, 5'd0);
        send_req(OP_ALLOC, 16'd64, 5'd0);
        send_req(OP_ALLOC, 16'd65, 5'd0);
        send_req(OP_ALLOC, 16'hFFFF, 5'd31);
    endtask

    task automatic test_free_handles();
        send_req(OP_FREE, 16'd0, 5'd0);
        send_req(OP_FREE, 16'hFFFF, 5'd10);
        send_req(OP_FREE, 16'd0, 5'd15);
        send_req(OP_FREE, 16'd0, 5'd20);
        send_req(OP_FREE, 16'd0, 5'd0);
        send_req(OP_FREE, 16'd0, 5'd29);
        send_req(OP_FREE, 16'd0, 5'd30);
        send_req(OP_FREE, 16'd0, 5'd31);
    endtask

    task automatic test_fallthrough();
        repeat (5) send_req(OP_ALLOC, 16'd32, 5'd0);
        send_req(OP_ALLOC, 16'd17, 5'd0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int          alloc_pct;
        int          r;
        logic [15:0] size;
        logic [4:0]  handle;
        int          live[$];
        logic [15:0] edges [14] = '{0, 1, 7, 8, 9, 15, 16, 17, 31, 32, 33, 63, 64, 65};
        alloc_pct = 50;
        for (int k = 0; k < n_items; k++) begin
            if (k % 80 == 0) begin
                r = $urandom_range(0, 2);
                alloc_pct = (r == 0) ? 90 : (r == 1) ? 50 : 15;
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < alloc_pct) begin
                if (r < 10) size = edges[$urandom_range(0, 13)];
                else if (r < 85) size = 16'($urandom_range(0, 64));
                else size = 16'($urandom_range(0, 65535));
                send_req(OP_ALLOC, size, 5'($urandom_range(0, 31)));
            end else begin
                live.delete();
                for (int b = 0; b < TOTAL_BLOCKS; b++) if (block_in_use[b]) live.push_back(b);
                if (r < 85 && live.size() != 0)
                    handle = 5'(live[$urandom_range(0, live.size() - 1)]);
                else handle = 5'($urandom_range(0, 31));
                send_req(OP_FREE, 16'($urandom_range(0, 65535)), handle);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_class_boundaries();
        test_free_handles();
        test_fallthrough();
        test_random_traffic(600);
        s_axis_tvalid <= 1'b0;
        drain_replies();
        test_random_traffic(600);
        s_axis_tvalid <= 1'b0;
        drain_replies();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d granted allocations and releases, %0d pool-full or oversize",
                 grants, rejects);
        $display("rejects and %0d out-of-range handles under random stalls on both sides",
                 bad_handles);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timeout: replies still outstanding: %0d", pending_replies.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
